// ----- rtl/core/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands used by the RTL that checks itself.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold on every clock edge outside reset.
`define SCL_ASSERT(lbl, clk_s, rst_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (prop)) \
    else $error(msg);

// Implication: cons must hold in the same cycle whenever ante holds.
`define SCL_ASSERT_IMPL(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error(msg);

// Implication: cons must hold in the cycle after ante.
`define SCL_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/scl2x_pkg.sv -----
// ----------------------------------------------------------------------------
// scl2x_pkg
// Types, sizes and the Scale2x pixel rule for the 2x upscaler.
// ----------------------------------------------------------------------------
`default_nettype none

package scl2x_pkg;

  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 2048;

  localparam int PIX_W = 32;                    // pixel word
  localparam int DIM_W = 12;                    // size registers
  localparam int SRC_W = 11;                    // coordinate fields of a result
  localparam int XW    = $clog2(MAX_WIDTH);     // column counter
  localparam int YW    = $clog2(MAX_HEIGHT);    // row counter

  // two row banks, row r lives in bank r mod 2
  localparam int LS_DEPTH = 2 * MAX_WIDTH;
  localparam int LS_AW    = $clog2(LS_DEPTH);

  // front-to-back queue
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // config register map
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = CFG_IDX_W'(1);

  localparam logic [DIM_W-1:0] WIDTH_RESET  = DIM_W'(640);
  localparam logic [DIM_W-1:0] HEIGHT_RESET = DIM_W'(480);

  // source pixel with its position and border flags
  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic [XW-1:0]    x;
    logic [YW-1:0]    y;
    logic             row_ge1;
    logic             row_ge2;
    logic             col_ge1;
    logic             col_ge2;
    logic             col_last;
    logic             row_last;
  } tag_t;

  // queue word: tag plus line store reads
  typedef struct packed {
    tag_t             tag;
    logic [PIX_W-1:0] up2;    // two rows up, same column
    logic [PIX_W-1:0] look;   // next value of the previous-row window
  } item_t;

  typedef struct packed {
    logic [PIX_W-1:0] tl;
    logic [PIX_W-1:0] tr;
    logic [PIX_W-1:0] bl;
    logic [PIX_W-1:0] br;
  } quad_t;

  typedef struct packed {
    logic [SRC_W-1:0] col;
    logic [SRC_W-1:0] row;
    quad_t            quad;
    logic             last;
  } res_t;

  // Scale2x: b up, d left, e center, f right, h down
  function automatic quad_t expand(input logic [PIX_W-1:0] b, input logic [PIX_W-1:0] d,
                                   input logic [PIX_W-1:0] e, input logic [PIX_W-1:0] f,
                                   input logic [PIX_W-1:0] h);
    quad_t q;
    q = '{tl: e, tr: e, bl: e, br: e};
    if ((b != h) && (d != f)) begin
      q.tl = (d == b) ? d : e;
      q.tr = (b == f) ? f : e;
      q.bl = (d == h) ? d : e;
      q.br = (h == f) ? f : e;
    end
    return q;
  endfunction

  // zero acts as one, oversize saturates
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v, input int lim);
    logic [DIM_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > DIM_W'(lim)) begin
      r = DIM_W'(lim);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/scl2x_ram.sv -----
// ----------------------------------------------------------------------------
// scl2x_ram
// Generic RAM: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module scl2x_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  localparam int AW   = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr_a,
  output logic      [WIDTH-1:0] rdata_a,
  input  wire logic [AW-1:0]    raddr_b,
  output logic      [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read returns the old word on a same-address write
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

`default_nettype wire

// ----- rtl/core/scl2x_front.sv -----
// ----------------------------------------------------------------------------
// scl2x_front
// Config registers, raster counters, line store access and border flags.
// ----------------------------------------------------------------------------
`default_nettype none

module scl2x_front import scl2x_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 push,
  input  wire logic [PIX_W-1:0]     pixel,
  output logic                      full,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [DIM_W-1:0]     cfg_data,
  input  wire logic [QCNT_W-1:0]    q_count,
  output logic                      q_push,
  output item_t                     q_item
);

  logic [DIM_W-1:0] width_eff;
  logic [DIM_W-1:0] height_eff;
  logic [XW-1:0]    x;
  logic [YW-1:0]    y;
  logic             s1_valid;
  tag_t             s1;
  logic             s1_bypass;

  logic             accept;
  logic             cfg_we;
  logic [QCNT_W:0]  in_use;
  tag_t             tag_now;
  logic             bypass;
  logic [LS_AW-1:0] wr_addr;
  logic [LS_AW-1:0] rd_b_addr;
  logic [PIX_W-1:0] up2_data;
  logic [PIX_W-1:0] look_data;

  // stage 1 always drains next cycle, so count it as taken
  assign in_use    = (QCNT_W+1)'(q_count) + (QCNT_W+1)'(s1_valid);
  assign full      = rst | (in_use >= (QCNT_W+1)'(QDEPTH));
  assign accept    = push & ~full;
  assign cfg_ready = ~rst;
  assign cfg_we    = cfg_valid & cfg_ready;

  always_comb begin
    tag_now.pixel    = pixel;
    tag_now.x        = x;
    tag_now.y        = y;
    tag_now.row_ge1  = (y != '0);
    tag_now.row_ge2  = (y >= YW'(2));
    tag_now.col_ge1  = (x != '0);
    tag_now.col_ge2  = (x >= XW'(2));
    tag_now.col_last = ((DIM_W'(x) + DIM_W'(1)) == width_eff);
    tag_now.row_last = ((DIM_W'(y) + DIM_W'(1)) == height_eff);
  end

  // At row end the lookahead fetches column 0 of this row for the next row;
  // with a one-pixel row that word is being written now, so take it direct.
  assign bypass    = tag_now.col_last & ~tag_now.col_ge1;
  assign wr_addr   = {y[0], x};
  assign rd_b_addr = tag_now.col_last ? {y[0], XW'(0)} : {~y[0], x + XW'(1)};

  scl2x_ram #(
    .WIDTH (PIX_W),
    .DEPTH (LS_DEPTH)
  ) u_line_store (
    .clk     (clk),
    .we      (accept),
    .waddr   (wr_addr),
    .wdata   (pixel),
    .raddr_a (wr_addr),
    .rdata_a (up2_data),
    .raddr_b (rd_b_addr),
    .rdata_b (look_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      width_eff  <= WIDTH_RESET;
      height_eff <= HEIGHT_RESET;
      x          <= '0;
      y          <= '0;
      s1_valid   <= 1'b0;
    end else begin
      s1_valid <= accept;
      if (cfg_we) begin
        case (cfg_index)
          REG_IMAGE_WIDTH: begin
            width_eff <= clamp_dim(cfg_data, MAX_WIDTH);
            x         <= '0;
            y         <= '0;
          end
          REG_IMAGE_HEIGHT: begin
            height_eff <= clamp_dim(cfg_data, MAX_HEIGHT);
            x          <= '0;
            y          <= '0;
          end
          default: begin
          end
        endcase
      end else if (accept) begin
        if (tag_now.col_last) begin
          x <= '0;
          y <= tag_now.row_last ? '0 : y + YW'(1);
        end else begin
          x <= x + XW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1        <= tag_now;
      s1_bypass <= bypass;
    end
  end

  assign q_push = s1_valid;

  always_comb begin
    q_item.tag  = s1;
    q_item.up2  = up2_data;
    q_item.look = s1_bypass ? s1.pixel : look_data;
  end

endmodule

`default_nettype wire

// ----- rtl/core/scl2x_queue.sv -----
// ----------------------------------------------------------------------------
// scl2x_queue
// Short FIFO of classified words between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module scl2x_queue import scl2x_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire item_t             din,
  input  wire logic              pop,
  output item_t                  head,
  output logic                   empty,
  output logic [QCNT_W-1:0]      count
);

  item_t             slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;

  assign head  = slots[rd_ptr];
  assign empty = (count == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      count <= count + QCNT_W'(push) - QCNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= din;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/scl2x_back.sv -----
// ----------------------------------------------------------------------------
// scl2x_back
// Neighbor windows, result sequencing and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module scl2x_back import scl2x_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire item_t q_head,
  input  wire logic  q_empty,
  output logic       q_pop,
  input  wire logic  pop,
  output logic       empty,
  output res_t       res
);

  // windows: pw* previous row at x-1, x; c* this row at x-2, x-1
  logic [PIX_W-1:0] pw0;
  logic [PIX_W-1:0] pw1;
  logic [PIX_W-1:0] c0;
  logic [PIX_W-1:0] c1;
  logic             done_a;
  logic             done_b;
  logic             out_valid;

  tag_t             t;
  logic             need_a;
  logic             need_b;
  logic             need_c;
  logic             sel_a;
  logic             sel_b;
  logic             sel_c;
  logic             have_res;
  logic             is_last;
  logic             out_ready;
  logic             load;
  logic             retire;
  logic [PIX_W-1:0] b;
  logic [PIX_W-1:0] d;
  logic [PIX_W-1:0] e;
  logic [PIX_W-1:0] f;
  logic [PIX_W-1:0] h;
  logic [XW-1:0]    rx;
  logic [YW-1:0]    ry;
  res_t             res_next;

  assign t = q_head.tag;

  // a: row above this one; b: left pixel of last row; c: last pixel of last row
  assign need_a   = t.row_ge1;
  assign need_b   = t.row_last & t.col_ge1;
  assign need_c   = t.row_last & t.col_last;
  assign sel_a    = need_a & ~done_a;
  assign sel_b    = need_b & ~done_b & ~sel_a;
  assign sel_c    = need_c & ~sel_a & ~sel_b;
  assign have_res = sel_a | sel_b | sel_c;
  assign is_last  = sel_c | (sel_b & ~need_c) | (sel_a & ~need_b & ~need_c);

  assign out_ready = ~out_valid | pop;
  assign load      = ~q_empty & have_res & out_ready;
  assign retire    = ~q_empty & (~have_res | (load & is_last));
  assign q_pop     = retire;
  assign empty     = ~out_valid;

  always_comb begin
    if (sel_a) begin
      e  = pw1;
      b  = t.row_ge2 ? q_head.up2 : pw1;
      d  = t.col_ge1 ? pw0 : pw1;
      f  = t.col_last ? pw1 : q_head.look;
      h  = t.pixel;
      rx = t.x;
      ry = t.y - YW'(1);
    end else if (sel_b) begin
      e  = c1;
      b  = t.row_ge1 ? pw0 : c1;
      d  = t.col_ge2 ? c0 : c1;
      f  = t.pixel;
      h  = c1;
      rx = t.x - XW'(1);
      ry = t.y;
    end else begin
      e  = t.pixel;
      b  = t.row_ge1 ? pw1 : t.pixel;
      d  = t.col_ge1 ? c1 : t.pixel;
      f  = t.pixel;
      h  = t.pixel;
      rx = t.x;
      ry = t.y;
    end
    res_next.col  = SRC_W'(rx);
    res_next.row  = SRC_W'(ry);
    res_next.quad = expand(b, d, e, f, h);
    res_next.last = is_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      done_a    <= 1'b0;
      done_b    <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
      if (retire) begin
        done_a <= 1'b0;
        done_b <= 1'b0;
      end else if (load) begin
        done_a <= done_a | sel_a;
        done_b <= done_b | sel_b;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res <= res_next;
    end
    if (retire) begin
      pw0 <= pw1;
      pw1 <= q_head.look;
      c0  <= c1;
      c1  <= t.pixel;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/scale2x_pixel_art_upscaler.sv -----
// ----------------------------------------------------------------------------
// scale2x_pixel_art_upscaler
// Streaming Scale2x 2x upscaler for raster-order 32-bit pixels.
// ----------------------------------------------------------------------------
// Usage:
//   Input side is a queue: drive pixel and push; a word is taken on a clock
//   edge with push high and full low. Pixels come in raster order.
//   Result side is a queue: while empty is low the oldest result (source
//   coordinate, four output pixels, last_of_run) is on the ports and is
//   taken on an edge with pop high.
//   Config: cfg_valid/cfg_ready write image_width (index 0) or
//   image_height (index 1); any such write restarts the frame at row 0.
//   Write only while the block is drained.
// Path: a taken pixel (x, r) passes the front stage and the queue; its result
//   for (x, r-1), and any last-row results, then load into the output register.
// Throughput: one pixel per cycle while results are popped, set by the single
//   result path into the output register. A pixel of the last row yields two
//   results (three at its end), so that row runs at a lower pixel rate.
// Reset: size returns to 640x480, counters and queues clear. The line store
//   is not cleared; every frame starts at row 0 and never reads stale rows.
// Stall: the output register holds, the 4-word queue fills, full rises.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module scale2x_pixel_art_upscaler import scl2x_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  // pixel input
  input  wire logic                 push,
  output logic                      full,
  input  wire logic [PIX_W-1:0]     pixel,
  // result output
  output logic                      empty,
  input  wire logic                 pop,
  output logic [SRC_W-1:0]          src_column,
  output logic [SRC_W-1:0]          src_row,
  output logic [PIX_W-1:0]          top_left,
  output logic [PIX_W-1:0]          top_right,
  output logic [PIX_W-1:0]          bottom_left,
  output logic [PIX_W-1:0]          bottom_right,
  output logic                      last_of_run,
  // config write
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [DIM_W-1:0]     cfg_data
);

  logic              q_push;
  item_t             q_item;
  item_t             q_head;
  logic              q_pop;
  logic              q_empty;
  logic [QCNT_W-1:0] q_count;
  res_t              res;
  logic [QCNT_W:0]   q_level;

  // front: counters, border flags, line store reads/writes
  scl2x_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .pixel     (pixel),
    .full      (full),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_count   (q_count),
    .q_push    (q_push),
    .q_item    (q_item)
  );

  // decouples fetch from the multi-result last row
  scl2x_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .din   (q_item),
    .pop   (q_pop),
    .head  (q_head),
    .empty (q_empty),
    .count (q_count)
  );

  // back: windows, Scale2x rule, one result per cycle into the output reg while it is free or popped
  scl2x_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_head  (q_head),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .pop     (pop),
    .empty   (empty),
    .res     (res)
  );

  assign src_column   = res.col;
  assign src_row      = res.row;
  assign top_left     = res.quad.tl;
  assign top_right    = res.quad.tr;
  assign bottom_left  = res.quad.bl;
  assign bottom_right = res.quad.br;
  assign last_of_run  = res.last;

  // words in the queue plus the one in the front stage
  assign q_level = (QCNT_W+1)'(q_count) + (QCNT_W+1)'(q_push);

  `SCL_ASSERT(a_queue_bound, clk, rst, q_level <= (QCNT_W+1)'(QDEPTH), "queue overrun")
  `SCL_ASSERT_IMPL(a_pop_nonempty, clk, rst, q_pop, !q_empty, "queue popped while empty")
  `SCL_ASSERT_NEXT(a_accept_staged, clk, rst, push && !full, q_push, "taken pixel not staged")

endmodule

`default_nettype wire

// ----- verif/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the streaming Scale2x upscaler. Pixels go in as
// raster frames at many image sizes. A behavioral model of the line stores
// and the 2x2 expansion rule predicts every result word, and each popped
// word is compared field by field against the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import scl2x_pkg::*;

  // Writes to these indexes must be dropped and must not restart the frame.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = CFG_IDX_W'(3);

  localparam int CYCLE_LIMIT  = 200000;  // bench timeout for the whole run
  localparam int DRAIN_CYCLES = 8;       // front stage, queue and output register, margin on top
  localparam int IDLE_PCT     = 30;

  // One expanded source pixel as it leaves the block.
  typedef struct packed {
    logic [SRC_W-1:0] col;
    logic [SRC_W-1:0] row;
    logic [PIX_W-1:0] tl;
    logic [PIX_W-1:0] tr;
    logic [PIX_W-1:0] bl;
    logic [PIX_W-1:0] br;
    logic             last;
  } block_t;

  // --------------------------------------------------------------------------
  // DUT inputs, all known from time zero
  // --------------------------------------------------------------------------
  logic                 clk;
  logic                 rst = 1'b1;
  logic                 push = 1'b0;
  logic                 full;
  logic [PIX_W-1:0]     pixel = '0;
  logic                 empty;
  logic                 pop = 1'b0;
  logic [SRC_W-1:0]     src_column;
  logic [SRC_W-1:0]     src_row;
  logic [PIX_W-1:0]     top_left;
  logic [PIX_W-1:0]     top_right;
  logic [PIX_W-1:0]     bottom_left;
  logic [PIX_W-1:0]     bottom_right;
  logic                 last_of_run;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DIM_W-1:0]     cfg_data = '0;

  scale2x_pixel_art_upscaler DUT (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .pixel        (pixel),
    .empty        (empty),
    .pop          (pop),
    .src_column   (src_column),
    .src_row      (src_row),
    .top_left     (top_left),
    .top_right    (top_right),
    .bottom_left  (bottom_left),
    .bottom_right (bottom_right),
    .last_of_run  (last_of_run),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // 12 ns period
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // --------------------------------------------------------------------------
  // Bench state
  // --------------------------------------------------------------------------
  logic [PIX_W-1:0] pixel_backlog[$];   // words waiting for the driver
  block_t           pending_blocks[$];  // predicted results, oldest first
  block_t           oldest;

  int unsigned queued_count  = 0;  // pixels handed to the driver
  int unsigned taken_count   = 0;  // pixels the block accepted
  int unsigned cfg_count     = 0;  // register writes accepted
  int unsigned blocks_seen   = 0;
  int unsigned frames_sent   = 0;
  int unsigned error_count   = 0;
  int unsigned cycle_count   = 0;
  bit          px_taken      = 1'b0;
  bit          steady        = 1'b0;  // both sides run flat out while set

  // predictor copy of the registers, frame position and both row banks
  logic [DIM_W-1:0] size_w = WIDTH_RESET;
  logic [DIM_W-1:0] size_h = HEIGHT_RESET;
  int unsigned      col_pos = 0;
  int unsigned      row_pos = 0;
  logic [PIX_W-1:0] row_mem [0:2*MAX_WIDTH-1];

  // small palette per frame so the neighbor equality tests actually fire
  logic [PIX_W-1:0] palette [0:2];
  int unsigned      palette_n = 2;

  initial begin
    for (int i = 0; i < 2 * MAX_WIDTH; i++) row_mem[i] = '0;
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    error_count++;
  endtask

  task automatic check_field(input string name, input logic [PIX_W-1:0] got,
                             input logic [PIX_W-1:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %h want %h at source (%0d,%0d)",
                                name, got, want, oldest.col, oldest.row));
  endtask

  // Scale2x on one source pixel: up, left, center, right, below.
  function automatic void add_block(input int unsigned col, input int unsigned row,
                                    input logic [PIX_W-1:0] up,
                                    input logic [PIX_W-1:0] left,
                                    input logic [PIX_W-1:0] center,
                                    input logic [PIX_W-1:0] right,
                                    input logic [PIX_W-1:0] below);
    block_t blk;
    blk.col  = SRC_W'(col);
    blk.row  = SRC_W'(row);
    blk.tl   = center;
    blk.tr   = center;
    blk.bl   = center;
    blk.br   = center;
    blk.last = 1'b0;
    if (up != below && left != right) begin
      blk.tl = (left == up)     ? left  : center;
      blk.tr = (up == right)    ? right : center;
      blk.bl = (left == below)  ? left  : center;
      blk.br = (below == right) ? right : center;
    end
    pending_blocks.push_back(blk);
  endfunction

  // Everything one accepted pixel causes: the block one row up, and on the
  // bottom row the block to its left, plus its own block at the row's end.
  task automatic predict_scale2x(input logic [PIX_W-1:0] p);
    int unsigned      w, h, x, r, cur, prev, n0;
    logic [PIX_W-1:0] b, d, e, f;
    w = (size_w == 0) ? 1 : ((size_w > MAX_WIDTH) ? MAX_WIDTH : size_w);
    h = (size_h == 0) ? 1 : ((size_h > MAX_HEIGHT) ? MAX_HEIGHT : size_h);
    x = (col_pos >= w) ? w - 1 : col_pos;
    r = (row_pos >= h) ? h - 1 : row_pos;
    cur  = r % 2;
    prev = 1 - cur;
    n0   = pending_blocks.size();

    if (r >= 1) begin
      e = row_mem[prev * MAX_WIDTH + x];
      b = (r >= 2)    ? row_mem[cur * MAX_WIDTH + x]      : e;
      d = (x >= 1)    ? row_mem[prev * MAX_WIDTH + x - 1] : e;
      f = (x + 1 < w) ? row_mem[prev * MAX_WIDTH + x + 1] : e;
      add_block(x, r - 1, b, d, e, f, p);
    end

    row_mem[cur * MAX_WIDTH + x] = p;

    if (r + 1 == h) begin
      if (x >= 1) begin
        e = row_mem[cur * MAX_WIDTH + x - 1];
        b = (r >= 1) ? row_mem[prev * MAX_WIDTH + x - 1] : e;
        d = (x >= 2) ? row_mem[cur * MAX_WIDTH + x - 2]  : e;
        add_block(x - 1, r, b, d, e, p, e);
      end
      if (x + 1 == w) begin
        e = p;
        b = (r >= 1) ? row_mem[prev * MAX_WIDTH + x]    : e;
        d = (x >= 1) ? row_mem[cur * MAX_WIDTH + x - 1] : e;
        add_block(x, r, b, d, e, e, e);
      end
    end

    if (pending_blocks.size() > n0)
      pending_blocks[pending_blocks.size() - 1].last = 1'b1;

    x++;
    if (x >= w) begin
      x = 0;
      r++;
      if (r >= h) r = 0;
    end
    col_pos = x;
    row_pos = r;
  endtask

  // --------------------------------------------------------------------------
  // Driver: pixel side and result side, both change on the falling edge
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst && (!push || px_taken)) begin
      if (pixel_backlog.size() > 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
        push  <= 1'b1;
        pixel <= pixel_backlog.pop_front();
      end else begin
        push  <= 1'b0;
        pixel <= $urandom;  // junk on the bus while push is low
      end
    end
  end

  always @(negedge clk) begin
    pop <= steady || ($urandom_range(99) >= IDLE_PCT);
  end

  // --------------------------------------------------------------------------
  // Monitor: all handshakes sampled on the rising edge
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TIMEOUT after %0d cycles, %0d results still expected",
               cycle_count, pending_blocks.size());
      $display("Verification failed");
      $finish;
    end else if (rst) begin
      px_taken = 1'b0;
    end else begin
      px_taken = push && !full;
      if (px_taken) begin
        taken_count++;
        predict_scale2x(pixel);
      end

      if (cfg_valid && cfg_ready) begin
        cfg_count++;
        // any mapped write restarts the frame, the row banks keep their data
        case (cfg_index)
          REG_IMAGE_WIDTH: begin
            size_w  = cfg_data;
            col_pos = 0;
            row_pos = 0;
          end
          REG_IMAGE_HEIGHT: begin
            size_h  = cfg_data;
            col_pos = 0;
            row_pos = 0;
          end
          default: ;
        endcase
      end

      if (pop && !empty) begin
        if (pending_blocks.size() == 0) begin
          report_mismatch($sformatf("result word (%0d,%0d) with nothing expected",
                                    src_column, src_row));
        end else begin
          oldest = pending_blocks.pop_front();
          check_field("src_column",   PIX_W'(src_column),  PIX_W'(oldest.col));
          check_field("src_row",      PIX_W'(src_row),     PIX_W'(oldest.row));
          check_field("top_left",     top_left,            oldest.tl);
          check_field("top_right",    top_right,           oldest.tr);
          check_field("bottom_left",  bottom_left,         oldest.bl);
          check_field("bottom_right", bottom_right,        oldest.br);
          check_field("last_of_run",  PIX_W'(last_of_run), PIX_W'(oldest.last));
          blocks_seen++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic void queue_pixel(input logic [PIX_W-1:0] p);
    pixel_backlog.push_back(p);
    queued_count++;
  endfunction

  function automatic logic [PIX_W-1:0] draw_pixel();
    if ($urandom_range(99) < 85) return palette[$urandom_range(palette_n - 1)];
    return $urandom;
  endfunction

  function automatic void new_palette();
    palette_n = $urandom_range(2, 3);
    for (int i = 0; i < 3; i++) palette[i] = $urandom;
  endfunction

  // Writes go out one at a time and only while the block is drained.
  task automatic write_size_reg(input logic [CFG_IDX_W-1:0] idx,
                                input logic [DIM_W-1:0] val);
    int unsigned seen;
    seen = cfg_count;
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(negedge clk); while (cfg_count == seen);
    cfg_valid <= 1'b0;
  endtask

  // Wait until every pixel is in and every predicted word is out; then give
  // pixels that make no result (top rows) time to clear the pipeline.
  task automatic settle();
    do @(negedge clk); while (taken_count != queued_count || pending_blocks.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic send_pixels(input int unsigned count);
    @(posedge clk);
    for (int unsigned i = 0; i < count; i++) queue_pixel(draw_pixel());
    frames_sent++;
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin : sequence_main
    logic [PIX_W-1:0] diag [0:8];
    int unsigned      w, h, frames, count, phase;
    bit               big;

    // row 0: A Z A / row 1: Z A A / row 2: A A Z  -- diagonal edges, extremes
    diag = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000,
             32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000,
             32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF};

    repeat (5) @(posedge clk);
    @(negedge clk) rst <= 1'b0;
    settle();

    // 3x3 frame, interrupted after row 0 plus one pixel by writes to the
    // unmapped indexes, which must leave the frame position alone
    write_size_reg(REG_IMAGE_WIDTH, DIM_W'(3));
    write_size_reg(REG_IMAGE_HEIGHT, DIM_W'(3));
    @(posedge clk);
    for (int i = 0; i < 4; i++) queue_pixel(diag[i]);
    settle();
    write_size_reg(REG_SPARE_LO, DIM_W'(12'hFFF));
    write_size_reg(REG_SPARE_HI, DIM_W'(0));
    @(posedge clk);
    for (int i = 4; i < 9; i++) queue_pixel(diag[i]);
    frames_sent++;
    settle();

    // zero sizes act as 1x1: every pixel is a whole frame, wrap each time
    write_size_reg(REG_IMAGE_WIDTH, DIM_W'(0));
    write_size_reg(REG_IMAGE_HEIGHT, DIM_W'(0));
    @(posedge clk);
    queue_pixel(32'h0000_0000);
    queue_pixel(32'hFFFF_FFFF);
    queue_pixel(32'hA5A5_5A5A);
    frames_sent += 3;
    settle();

    // oversize width clamps to the widest row, one row tall
    new_palette();
    write_size_reg(REG_IMAGE_WIDTH, DIM_W'(12'hFFF));
    write_size_reg(REG_IMAGE_HEIGHT, DIM_W'(1));
    send_pixels(6);
    settle();

    // oversize height clamps to the tallest frame, one column wide
    new_palette();
    write_size_reg(REG_IMAGE_WIDTH, DIM_W'(1));
    write_size_reg(REG_IMAGE_HEIGHT, DIM_W'(12'hFFF));
    send_pixels(6);
    settle();

    // random frames, mostly complete, some cut short
    phase = 0;
    while (queued_count < 440) begin
      big = 1'b0;
      if (phase == 3) begin
        // long stretch with no idling on either side
        w = 8;
        h = 6;
        steady = 1'b1;
      end else if ($urandom_range(9) == 0) begin
        big = 1'b1;
        if ($urandom_range(1)) begin
          w = MAX_WIDTH;
          h = 1;
        end else begin
          w = 1;
          h = MAX_HEIGHT;
        end
      end else if ($urandom_range(4) == 0) begin
        w = $urandom_range(11, 40);
        h = $urandom_range(1, 2);
      end else begin
        w = $urandom_range(1, 10);
        h = $urandom_range(1, 6);
      end

      if ($urandom_range(1)) begin
        write_size_reg(REG_IMAGE_WIDTH, DIM_W'(w));
        write_size_reg(REG_IMAGE_HEIGHT, DIM_W'(h));
      end else begin
        write_size_reg(REG_IMAGE_HEIGHT, DIM_W'(h));
        write_size_reg(REG_IMAGE_WIDTH, DIM_W'(w));
      end

      frames = (big || phase == 3) ? ((phase == 3) ? 2 : 1) : $urandom_range(1, 2);
      for (int unsigned k = 0; k < frames; k++) begin
        new_palette();
        count = w * h;
        if (big)
          count = $urandom_range(8, 30);
        else if (phase != 3 && $urandom_range(5) == 0)
          count = $urandom_range(1, w * h);  // broken frame, next one picks up mid-way
        send_pixels(count);
      end
      settle();
      steady = 1'b0;

      if ($urandom_range(7) == 0)
        write_size_reg($urandom_range(1) ? REG_SPARE_LO : REG_SPARE_HI, DIM_W'($urandom));
      phase++;
    end

    settle();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (pending_blocks.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_blocks.size()));

    $display("Summary: %0d pixels in %0d frames, %0d register writes, %0d result words checked",
             taken_count, frames_sent, cfg_count, blocks_seen);
    $display("Summary: 1x1, 3x3 diagonal, clamped max-width and max-height runs, %0d mismatches",
             error_count);
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- scale2x_pixel_art_upscaler.f -----
+incdir+rtl/core
rtl/core/scl2x_pkg.sv
rtl/core/scl2x_ram.sv
rtl/core/scl2x_front.sv
rtl/core/scl2x_queue.sv
rtl/core/scl2x_back.sv
rtl/core/scale2x_pixel_art_upscaler.sv
verif/testbench.sv
